### hw/rtl/bcdec_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the BC1/BC2/BC3 block decoder.
// Used by every module of the decoder.
package bcdec_pkg;

	localparam logic [15:0] MAX_DIMENSION = 16'd32768;

	localparam logic [1:0] REG_FORMAT_MODE  = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [15:0] RESET_DIMENSION = 16'd1024;

	localparam logic [9:0]  DIV3_MUL  = 10'd683;
	localparam logic [11:0] DIV5_MUL  = 12'd3277;
	localparam logic [11:0] DIV7_MUL  = 12'd2341;

	typedef enum logic [1:0] {
		MODE_BC1 = 2'd0,
		MODE_BC2 = 2'd1,
		MODE_BC3 = 2'd2
	} mode_t;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t a;
	} rgba_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] width;
		logic [15:0] height;
	} cfg_t;

	typedef struct packed {
		logic [12:0]     bx;
		logic [12:0]     by;
		logic [31:0]     idx;
		logic [63:0]     ab;
		mode_t           mode;
		logic [15:0]     mask;
		rgba_t [3:0]     cpal;
		chan_t [7:0]     apal;
	} pal_item_t;

	function automatic chan_t widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic chan_t widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// Truncating divisions by reciprocal multiplication, exact over the ranges used.
	function automatic chan_t div3(input logic [9:0] v);
		logic [19:0] prod;
		prod = {10'd0, v} * {10'd0, DIV3_MUL};
		return prod[18:11];
	endfunction

	function automatic chan_t div5(input logic [10:0] v);
		logic [22:0] prod;
		prod = {12'd0, v} * {11'd0, DIV5_MUL};
		return prod[21:14];
	endfunction

	function automatic chan_t div7(input logic [10:0] v);
		logic [22:0] prod;
		prod = {12'd0, v} * {11'd0, DIV7_MUL};
		return prod[21:14];
	endfunction

endpackage

### hw/rtl/bcdec_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for compressed blocks and decoded pixels.
// Depends on nothing but plain logic types.
interface bcdec_block_if;
	logic        valid;
	logic        ready;
	logic [12:0] block_col;
	logic [12:0] block_row;
	logic [63:0] color_block;
	logic [63:0] alpha_block;

	modport source (output valid, block_col, block_row, color_block, alpha_block,
		input ready);
	modport sink (input valid, block_col, block_row, color_block, alpha_block,
		output ready);
endinterface

interface bcdec_pixel_if;
	logic        valid;
	logic        ready;
	logic [14:0] pixel_x;
	logic [14:0] pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        last;

	modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha, last,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, red, green, blue, alpha, last,
		output ready);
endinterface

### hw/rtl/bcdec_palette.sv
`timescale 1ns / 1ps
// Three-stage pipeline that builds the color and alpha palettes and the in-image mask.
// Depends on bcdec_pkg and bcdec_block_if.
module bcdec_palette (
	input  logic               clk,
	input  logic               arst_n,
	input  bcdec_pkg::cfg_t    cfg,
	bcdec_block_if.sink        blk,
	output logic               pal_valid,
	input  logic               pal_ready,
	output bcdec_pkg::pal_item_t pal_item
);
	import bcdec_pkg::*;

	logic        rdy_s1, rdy_s2, rdy_s3;
	logic        v_s1, v_s2, v_s3;

	logic [3:0]  col_ok, row_ok;
	logic [15:0] mask_in;
	logic        four_in;
	chan_t [2:0] e0_in, e1_in;

	logic [12:0] bx_s1, by_s1;
	logic [31:0] idx_s1;
	logic [63:0] ab_s1;
	mode_t       mode_s1;
	logic [15:0] mask_s1;
	logic        four_s1;
	chan_t [2:0] e0_s1, e1_s1;

	logic [9:0]  csa_c [3];
	logic [9:0]  csb_c [3];
	logic [8:0]  csh_c [3];
	logic [10:0] as7_c [6];
	logic [10:0] as5_c [4];

	logic [12:0] bx_s2, by_s2;
	logic [31:0] idx_s2;
	logic [63:0] ab_s2;
	mode_t       mode_s2;
	logic [15:0] mask_s2;
	logic        four_s2;
	logic        agt_s2;
	chan_t [2:0] e0_s2, e1_s2;
	logic [9:0]  csa_s2 [3];
	logic [9:0]  csb_s2 [3];
	logic [8:0]  csh_s2 [3];
	logic [10:0] as7_s2 [6];
	logic [10:0] as5_s2 [4];

	pal_item_t   item_c;
	pal_item_t   item_s3;

	assign rdy_s3    = !v_s3 || pal_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign blk.ready = rdy_s1;
	assign pal_valid = v_s3;
	assign pal_item  = item_s3;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			col_ok[c] = {1'b0, blk.block_col, 2'(c)} < cfg.width;
			row_ok[c] = {1'b0, blk.block_row, 2'(c)} < cfg.height;
		end
		for (int p = 0; p < 16; p++) begin
			mask_in[p] = col_ok[p % 4] && row_ok[p / 4];
		end
		four_in = (blk.color_block[15:0] > blk.color_block[31:16]) || (cfg.mode != MODE_BC1);
		e0_in[0] = widen5(blk.color_block[15:11]);
		e0_in[1] = widen6(blk.color_block[10:5]);
		e0_in[2] = widen5(blk.color_block[4:0]);
		e1_in[0] = widen5(blk.color_block[31:27]);
		e1_in[1] = widen6(blk.color_block[26:21]);
		e1_in[2] = widen5(blk.color_block[20:16]);
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			csa_c[ch] = {1'b0, e0_s1[ch], 1'b0} + {2'b0, e1_s1[ch]};
			csb_c[ch] = {2'b0, e0_s1[ch]} + {1'b0, e1_s1[ch], 1'b0};
			csh_c[ch] = {1'b0, e0_s1[ch]} + {1'b0, e1_s1[ch]};
		end
		for (int k = 0; k < 6; k++) begin
			as7_c[k] = 11'(6 - k) * {3'b0, ab_s1[7:0]} + 11'(k + 1) * {3'b0, ab_s1[15:8]};
		end
		for (int k = 0; k < 4; k++) begin
			as5_c[k] = 11'(4 - k) * {3'b0, ab_s1[7:0]} + 11'(k + 1) * {3'b0, ab_s1[15:8]};
		end
	end

	always_comb begin
		item_c.bx   = bx_s2;
		item_c.by   = by_s2;
		item_c.idx  = idx_s2;
		item_c.ab   = ab_s2;
		item_c.mode = mode_s2;
		item_c.mask = mask_s2;
		item_c.cpal[0] = '{r: e0_s2[0], g: e0_s2[1], b: e0_s2[2], a: 8'hff};
		item_c.cpal[1] = '{r: e1_s2[0], g: e1_s2[1], b: e1_s2[2], a: 8'hff};
		if (four_s2) begin
			item_c.cpal[2] = '{r: div3(csa_s2[0]), g: div3(csa_s2[1]), b: div3(csa_s2[2]),
				a: 8'hff};
			item_c.cpal[3] = '{r: div3(csb_s2[0]), g: div3(csb_s2[1]), b: div3(csb_s2[2]),
				a: 8'hff};
		end else begin
			item_c.cpal[2] = '{r: csh_s2[0][8:1], g: csh_s2[1][8:1], b: csh_s2[2][8:1],
				a: 8'hff};
			item_c.cpal[3] = '0;
		end
		item_c.apal[0] = ab_s2[7:0];
		item_c.apal[1] = ab_s2[15:8];
		if (agt_s2) begin
			for (int k = 0; k < 6; k++) begin
				item_c.apal[k + 2] = div7(as7_s2[k]);
			end
		end else begin
			for (int k = 0; k < 4; k++) begin
				item_c.apal[k + 2] = div5(as5_s2[k]);
			end
			item_c.apal[6] = 8'h00;
			item_c.apal[7] = 8'hff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= blk.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && blk.valid) begin
			bx_s1   <= blk.block_col;
			by_s1   <= blk.block_row;
			idx_s1  <= blk.color_block[63:32];
			ab_s1   <= blk.alpha_block;
			mode_s1 <= cfg.mode;
			mask_s1 <= mask_in;
			four_s1 <= four_in;
			e0_s1   <= e0_in;
			e1_s1   <= e1_in;
		end
		if (rdy_s2 && v_s1) begin
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
			idx_s2  <= idx_s1;
			ab_s2   <= ab_s1;
			mode_s2 <= mode_s1;
			mask_s2 <= mask_s1;
			four_s2 <= four_s1;
			agt_s2  <= ab_s1[7:0] > ab_s1[15:8];
			e0_s2   <= e0_s1;
			e1_s2   <= e1_s1;
			csa_s2  <= csa_c;
			csb_s2  <= csb_c;
			csh_s2  <= csh_c;
			as7_s2  <= as7_c;
			as5_s2  <= as5_c;
		end
		if (rdy_s3 && v_s2) begin
			item_s3 <= item_c;
		end
	end

endmodule

### hw/rtl/bcdec_emit.sv
`timescale 1ns / 1ps
// Pixel emitter: walks the in-image pixels of one block and drives the registered pixel output.
// Depends on bcdec_pkg and bcdec_pixel_if.
module bcdec_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pal_valid,
	output logic                 pal_ready,
	input  bcdec_pkg::pal_item_t pal_item,
	bcdec_pixel_if.source        pix
);
	import bcdec_pkg::*;

	typedef struct packed {
		logic [14:0] x;
		logic [14:0] y;
		rgba_t       color;
		logic        last;
	} pixel_t;

	logic        busy_s4;
	logic [15:0] rem_s4;
	pal_item_t   blk_s4;

	logic        pix_vld_s5;
	pixel_t      pix_s5;

	logic        out_free;
	logic        emit;
	logic        last_px;
	logic [15:0] pick;
	logic [3:0]  p;
	logic [1:0]  ci;
	logic [3:0]  nib;
	logic [5:0]  aoff;
	logic [2:0]  ai;
	rgba_t       color;
	pixel_t      pix_c;

	always_comb begin
		out_free  = !pix_vld_s5 || pix.ready;
		emit      = busy_s4 && out_free;
		pick      = rem_s4 & (~rem_s4 + 16'd1);
		last_px   = (rem_s4 & (rem_s4 - 16'd1)) == 16'd0;
		pal_ready = !busy_s4 || (emit && last_px);
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			p = p | (pick[i] ? 4'(i) : 4'd0);
		end
		ci    = blk_s4.idx[{p, 1'b0} +: 2];
		nib   = blk_s4.ab[{p, 2'b00} +: 4];
		aoff  = 6'd16 + {1'b0, p, 1'b0} + {2'b00, p};
		ai    = blk_s4.ab[aoff +: 3];
		color = blk_s4.cpal[ci];
		case (blk_s4.mode)
			MODE_BC2: color.a = {nib, nib};
			MODE_BC3: color.a = blk_s4.apal[ai];
			default:  color.a = blk_s4.cpal[ci].a;
		endcase
		pix_c.x     = {blk_s4.bx, p[1:0]};
		pix_c.y     = {blk_s4.by, p[3:2]};
		pix_c.color = color;
		pix_c.last  = last_px;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s4    <= 1'b0;
			rem_s4     <= 16'd0;
			pix_vld_s5 <= 1'b0;
		end else begin
			if (pal_ready) begin
				busy_s4 <= pal_valid && (pal_item.mask != 16'd0);
				rem_s4  <= pal_item.mask;
			end else if (emit) begin
				rem_s4 <= rem_s4 & ~pick;
			end
			if (out_free) pix_vld_s5 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_ready && pal_valid) blk_s4 <= pal_item;
		if (emit) pix_s5 <= pix_c;
	end

	assign pix.valid   = pix_vld_s5;
	assign pix.pixel_x = pix_s5.x;
	assign pix.pixel_y = pix_s5.y;
	assign pix.red     = pix_s5.color.r;
	assign pix.green   = pix_s5.color.g;
	assign pix.blue    = pix_s5.color.b;
	assign pix.alpha   = pix_s5.color.a;
	assign pix.last    = pix_s5.last;

endmodule

### hw/rtl/bc1_bc3_block_decoder.sv
`timescale 1ns / 1ps
// Top level of the BC1/BC2/BC3 texture block decoder with its configuration registers.
// Depends on bcdec_pkg, bcdec_if, bcdec_palette and bcdec_emit.

// Each accepted block yields its in-image pixels in raster order, one pixel per cycle on the
// pixel port while the port is ready, with last set on the final one. The first pixel is
// valid once the block has passed the three palette stages, the pixel emitter and the
// output register, the first of which is loaded at the clock edge that accepts the block.
// A block that lies wholly outside the image is consumed by the emitter and produces
// nothing. New blocks are accepted while earlier ones are still being emitted, up to the
// depth of the palette pipeline. Write the configuration registers only while no block is
// in flight.
module bc1_bc3_block_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_wdata,
	bcdec_block_if.sink  blk,
	bcdec_pixel_if.source pix
);
	import bcdec_pkg::*;

	logic [1:0]  format_mode_q;
	logic [15:0] image_width_q;
	logic [15:0] image_height_q;

	cfg_t        cfg;
	logic        pal_valid;
	logic        pal_ready;
	pal_item_t   pal_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q  <= MODE_BC1;
			image_width_q  <= RESET_DIMENSION;
			image_height_q <= RESET_DIMENSION;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FORMAT_MODE:  format_mode_q  <= cfg_wdata[1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (format_mode_q)
			MODE_BC2: cfg.mode = MODE_BC2;
			MODE_BC3: cfg.mode = MODE_BC3;
			default:  cfg.mode = MODE_BC1;
		endcase
		cfg.width  = (image_width_q > MAX_DIMENSION) ? MAX_DIMENSION : image_width_q;
		cfg.height = (image_height_q > MAX_DIMENSION) ? MAX_DIMENSION : image_height_q;
	end

	bcdec_palette u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.blk       (blk),
		.pal_valid (pal_valid),
		.pal_ready (pal_ready),
		.pal_item  (pal_item)
	);

	bcdec_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.pal_valid (pal_valid),
		.pal_ready (pal_ready),
		.pal_item  (pal_item),
		.pix       (pix)
	);

	// Every emitted pixel lies inside the configured image.
	a_pixel_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> ({1'b0, pix.pixel_x} < cfg.width) && ({1'b0, pix.pixel_y} < cfg.height))
		else $error("pixel outside image");

	// In BC1 a pixel is either opaque or transparent black.
	a_bc1_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && (cfg.mode == MODE_BC1) |-> (pix.alpha == 8'hff) ||
		((pix.alpha == 8'h00) && (pix.red == 8'h00) && (pix.green == 8'h00) &&
		(pix.blue == 8'h00)))
		else $error("bad BC1 alpha");

	// Pixels of one block follow each other without a gap.
	a_block_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && !pix.last |=> pix.valid)
		else $error("gap inside a block");

	// A palette item that waits for the emitter is held unchanged.
	a_pal_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pal_valid && !pal_ready |=> pal_valid && $stable(pal_item))
		else $error("palette item lost");

endmodule
